[hdl/mtwd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mtwd_pkg;

  // Table geometry
  localparam int unsigned SLOTS  = 8;
  localparam int unsigned PASS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned TOT_W  = $clog2(SLOTS + 1);

  // Field widths
  localparam int unsigned ID_W   = 8;
  localparam int unsigned CNT_W  = 32;
  localparam logic [CNT_W-1:0] RELOAD_RST = CNT_W'(1000);

  typedef enum logic [2:0] {
    MODE_REGISTER   = 3'd0,
    MODE_UNREGISTER = 3'd1,
    MODE_FEED       = 3'd2,
    MODE_CHECKIN    = 3'd3,
    MODE_START      = 3'd4,
    MODE_STOP       = 3'd5,
    MODE_TICK       = 3'd6,
    MODE_RESTART    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_DUPLICATE   = 3'd1,
    STS_FULL        = 3'd2,
    STS_NOT_FOUND   = 3'd3,
    STS_NOT_RUNNING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RUN_IDLE    = 2'd0,
    RUN_ACTIVE  = 2'd1,
    RUN_TIMEOUT = 2'd2
  } run_e;

  // Operation applied by the head cell to the entry passing through it
  typedef enum logic [2:0] {
    OP_PASS         = 3'd0,
    OP_INSERT       = 3'd1,
    OP_DROP_ID      = 3'd2,
    OP_RELOAD_ID    = 3'd3,
    OP_RELOAD_VALID = 3'd4,
    OP_RELOAD_ALL   = 3'd5,
    OP_TICK         = 3'd6
  } cell_op_e;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    cell_op_e         op;
    logic             armed;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] elapsed;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic free;
    logic hit;
  } cell_flags_t;

endpackage

`default_nettype wire

[hdl/mtwd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mtwd_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                shift_i,
  input  wire mtwd_pkg::cell_ctl_t ctl_i,
  input  wire mtwd_pkg::entry_t    entry_i,
  output mtwd_pkg::entry_t         entry_o,
  output mtwd_pkg::cell_flags_t    flags_o
);

  mtwd_pkg::entry_t entry_q;
  mtwd_pkg::entry_t entry_d;

  // Flags on the entry arriving from the neighbour
  always_comb begin
    flags_o.match = entry_i.valid && (entry_i.id == ctl_i.id);
    flags_o.free  = !entry_i.valid;
    flags_o.hit   = entry_i.valid && (entry_i.cnt <= ctl_i.elapsed);
  end

  // Apply the command to the entry on its way through
  always_comb begin
    entry_d = entry_i;
    case (ctl_i.op)
      mtwd_pkg::OP_PASS: begin
        entry_d = entry_i;
      end
      mtwd_pkg::OP_INSERT: begin
        if (ctl_i.armed && !entry_i.valid) begin
          entry_d.valid = 1'b1;
          entry_d.id    = ctl_i.id;
          entry_d.cnt   = ctl_i.reload;
        end
      end
      mtwd_pkg::OP_DROP_ID: begin
        if (flags_o.match) begin
          entry_d = '0;
        end
      end
      mtwd_pkg::OP_RELOAD_ID: begin
        if (flags_o.match) begin
          entry_d.cnt = ctl_i.reload;
        end
      end
      mtwd_pkg::OP_RELOAD_VALID: begin
        if (entry_i.valid) begin
          entry_d.cnt = ctl_i.reload;
        end
      end
      mtwd_pkg::OP_RELOAD_ALL: begin
        entry_d.cnt = ctl_i.reload;
      end
      mtwd_pkg::OP_TICK: begin
        if (flags_o.hit) begin
          entry_d.cnt = '0;
        end else if (entry_i.valid) begin
          entry_d.cnt = entry_i.cnt - ctl_i.elapsed;
        end
      end
      default: begin
        entry_d = entry_i;
      end
    endcase
  end

  // Ring stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[hdl/multi_task_watchdog_monitor_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Multi-task watchdog monitor.
// Commands enter on the s_axis channel: tuser carries the mode, tdata the task
// id and the elapsed time of a tick. Each command yields one status transfer on
// the m_axis channel with status, feed pulse, reset request, run state and the
// number of registered tasks.
// The slot table sits in a ring of SLOTS cells. A command is served by one full
// rotation of the ring, with the head cell applying the command to each entry
// as it passes. A registration that finds no duplicate and a free slot takes a
// second rotation to write the entry.
// One command is in flight at a time. The result is loaded into the output
// register after the scan, or after the write rotation for a registration that
// succeeds; the next command is accepted once the block is back in idle after
// the result is loaded.
// The result sits in an output register. While the receiver stalls, the next
// command is still accepted and served; its result waits in the block until the
// output register is free, and s_axis_tready stays low meanwhile.
// After reset the table is empty, the monitor is idle and the reload value is
// 1000. cfg_we_i writes the reload value; write it only while the block is idle.

module multi_task_watchdog_monitor_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: reload value
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Command stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [7:0] task_id, [39:8] elapsed
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] mode
  // Result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata   // [2:0] status, [3] feed_pulse,
                                          // [4] reset_request, [6:5] run_state,
                                          // [10:7] active_count, [15:11] zero
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_INSERT = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  typedef struct packed {
    logic [3:0]       count;
    mtwd_pkg::run_e   run;
    logic             rst;
    logic             feed;
    mtwd_pkg::status_e status;
  } result_t;

  localparam logic [mtwd_pkg::PASS_W-1:0] PASS_LAST =
    mtwd_pkg::PASS_W'(mtwd_pkg::SLOTS - 1);

  state_e state_q, state_d;
  logic [mtwd_pkg::PASS_W-1:0] pass_q, pass_d;
  logic [mtwd_pkg::CNT_W-1:0]  reload_q;
  mtwd_pkg::mode_e    mode_q, mode_d;
  mtwd_pkg::cell_op_e op_q, op_d;
  logic [mtwd_pkg::ID_W-1:0]  id_q, id_d;
  logic [mtwd_pkg::CNT_W-1:0] elapsed_q, elapsed_d;
  logic armed_q, armed_d;
  logic found_q, found_d, free_q, free_d, hit_q, hit_d;
  mtwd_pkg::status_e status_q, status_d;
  logic feed_q, feed_d, rst_q, rst_d;
  mtwd_pkg::run_e run_q, run_d;
  logic [mtwd_pkg::TOT_W-1:0] total_q, total_d;
  result_t out_q, out_d;
  logic    out_vld_q, out_vld_d;

  logic pass_last;
  logic shift;
  logic out_free;
  logic s_xfer;
  logic found_all, free_all, hit_all;

  mtwd_pkg::entry_t      ring [mtwd_pkg::SLOTS];
  mtwd_pkg::cell_ctl_t   head_ctl;
  mtwd_pkg::cell_ctl_t   idle_ctl;
  mtwd_pkg::cell_flags_t head_flags;
  logic [mtwd_pkg::SLOTS-1:0] valid_vec;

  assign s_axis_tready = state_q == S_IDLE;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign shift         = (state_q == S_SCAN) || (state_q == S_INSERT);
  assign pass_last     = pass_q == PASS_LAST;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Command for the head cell; the other cells only move entries on
  always_comb begin
    head_ctl.op      = op_q;
    head_ctl.armed   = armed_q;
    head_ctl.id      = id_q;
    head_ctl.reload  = reload_q;
    head_ctl.elapsed = elapsed_q;
    idle_ctl         = head_ctl;
    idle_ctl.op      = mtwd_pkg::OP_PASS;
  end

  // Ring of slot cells
  for (genvar k = 0; k < mtwd_pkg::SLOTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      mtwd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .ctl_i   (head_ctl),
        .entry_i (ring[mtwd_pkg::SLOTS-1]),
        .entry_o (ring[k]),
        .flags_o (head_flags)
      );
    end else begin : g_body
      mtwd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .ctl_i   (idle_ctl),
        .entry_i (ring[k-1]),
        .entry_o (ring[k]),
        .flags_o ()
      );
    end
    assign valid_vec[k] = ring[k].valid;
  end

  assign found_all = found_q || head_flags.match;
  assign free_all  = free_q  || head_flags.free;
  assign hit_all   = hit_q   || head_flags.hit;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    mode_d    = mode_q;
    op_d      = op_q;
    id_d      = id_q;
    elapsed_d = elapsed_q;
    armed_d   = armed_q;
    found_d   = found_q;
    free_d    = free_q;
    hit_d     = hit_q;
    status_d  = status_q;
    feed_d    = feed_q;
    rst_d     = rst_q;
    run_d     = run_q;
    total_d   = total_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          mode_d    = mtwd_pkg::mode_e'(s_axis_tuser);
          id_d      = s_axis_tdata[7:0];
          elapsed_d = s_axis_tdata[39:8];
          pass_d    = '0;
          armed_d   = 1'b0;
          found_d   = 1'b0;
          free_d    = 1'b0;
          hit_d     = 1'b0;
          status_d  = mtwd_pkg::STS_OK;
          feed_d    = 1'b0;
          rst_d     = 1'b0;
          state_d   = S_SCAN;
          case (mtwd_pkg::mode_e'(s_axis_tuser))
            mtwd_pkg::MODE_REGISTER:   op_d = mtwd_pkg::OP_PASS;
            mtwd_pkg::MODE_UNREGISTER: op_d = mtwd_pkg::OP_DROP_ID;
            mtwd_pkg::MODE_FEED,
            mtwd_pkg::MODE_CHECKIN:    op_d = mtwd_pkg::OP_RELOAD_ID;
            mtwd_pkg::MODE_START:      op_d = (run_q != mtwd_pkg::RUN_ACTIVE) ?
                                              mtwd_pkg::OP_RELOAD_VALID :
                                              mtwd_pkg::OP_PASS;
            mtwd_pkg::MODE_STOP:       op_d = mtwd_pkg::OP_PASS;
            mtwd_pkg::MODE_TICK:       op_d = (run_q == mtwd_pkg::RUN_ACTIVE) ?
                                              mtwd_pkg::OP_TICK :
                                              mtwd_pkg::OP_PASS;
            mtwd_pkg::MODE_RESTART:    op_d = mtwd_pkg::OP_RELOAD_ALL;
            default:                   op_d = mtwd_pkg::OP_PASS;
          endcase
        end
      end

      S_SCAN: begin
        found_d = found_all;
        free_d  = free_all;
        hit_d   = hit_all;
        pass_d  = pass_q + 1'b1;
        if (pass_last) begin
          pass_d  = '0;
          state_d = S_DONE;
          case (mode_q)
            mtwd_pkg::MODE_REGISTER: begin
              if (found_all) begin
                status_d = mtwd_pkg::STS_DUPLICATE;
              end else if (!free_all) begin
                status_d = mtwd_pkg::STS_FULL;
              end else begin
                op_d    = mtwd_pkg::OP_INSERT;
                armed_d = 1'b1;
                state_d = S_INSERT;
              end
            end
            mtwd_pkg::MODE_UNREGISTER: begin
              if (found_all) begin
                if (total_q != '0) begin
                  total_d = total_q - 1'b1;
                end
              end else begin
                status_d = mtwd_pkg::STS_NOT_FOUND;
              end
            end
            mtwd_pkg::MODE_FEED,
            mtwd_pkg::MODE_CHECKIN: begin
              if (!found_all) begin
                status_d = mtwd_pkg::STS_NOT_FOUND;
              end
            end
            mtwd_pkg::MODE_START: begin
              run_d = mtwd_pkg::RUN_ACTIVE;
            end
            mtwd_pkg::MODE_STOP,
            mtwd_pkg::MODE_RESTART: begin
              run_d = mtwd_pkg::RUN_IDLE;
            end
            mtwd_pkg::MODE_TICK: begin
              if (run_q != mtwd_pkg::RUN_ACTIVE) begin
                status_d = mtwd_pkg::STS_NOT_RUNNING;
              end else if (hit_all) begin
                run_d = mtwd_pkg::RUN_TIMEOUT;
                rst_d = 1'b1;
              end else begin
                feed_d = 1'b1;
              end
            end
            default: begin
              status_d = status_q;
            end
          endcase
        end
      end

      S_INSERT: begin
        // First free entry seen takes the new task
        if (armed_q && head_flags.free) begin
          armed_d = 1'b0;
        end
        pass_d = pass_q + 1'b1;
        if (pass_last) begin
          pass_d  = '0;
          op_d    = mtwd_pkg::OP_PASS;
          total_d = total_q + 1'b1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_d.status = status_q;
          out_d.feed   = feed_q;
          out_d.rst    = rst_q;
          out_d.run    = run_q;
          out_d.count  = 4'(total_q);
          out_vld_d    = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pass_q    <= '0;
      op_q      <= mtwd_pkg::OP_PASS;
      armed_q   <= 1'b0;
      run_q     <= mtwd_pkg::RUN_IDLE;
      total_q   <= '0;
      out_vld_q <= 1'b0;
      reload_q  <= mtwd_pkg::RELOAD_RST;
    end else begin
      state_q   <= state_d;
      pass_q    <= pass_d;
      op_q      <= op_d;
      armed_q   <= armed_d;
      run_q     <= run_d;
      total_q   <= total_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        reload_q <= cfg_wdata_i;
      end
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    id_q      <= id_d;
    elapsed_q <= elapsed_d;
    found_q   <= found_d;
    free_q    <= free_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
    feed_q    <= feed_d;
    rst_q     <= rst_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q};

  // Task count tracks the valid entries whenever the block is idle
  a_total_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(valid_vec) == 32'(total_q)))
    else $error("task count differs from valid slots");

  // A registration pass always places its entry
  a_insert_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT && pass_last) |-> (!armed_q || head_flags.free))
    else $error("registration pass ended without a free slot");

  // Feed and reset request never in the same result
  a_feed_xor_rst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("feed pulse and reset request together");

endmodule

`default_nettype wire
